// File: design/swam_pkg.sv
// Shared constants and stage types for the sliding window magnitude mean.
// No dependencies; used by every module of the block.
package swam_pkg;

	localparam int WINDOW_MAX = 1024;
	localparam int ADDR_W     = $clog2(WINDOW_MAX);
	localparam int LEN_W      = ADDR_W + 1;
	localparam int SAMPLE_W   = 16;
	localparam int MAG_W      = 16;
	localparam int SUM_W      = 26;
	localparam int RECIP_W    = 17;
	localparam int LEVEL_W    = 16;
	localparam int FRAC_W     = 16;
	localparam int PROD_W     = SUM_W + RECIP_W;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(WINDOW_MAX);
	localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(64);

	// register index, taken from paddr[2]
	localparam logic REG_WINDOW_LENGTH = 1'b0;
	localparam logic REG_WINDOW_RECIP  = 1'b1;

	// ring stage output, one request after acceptance
	typedef struct packed {
		logic             valid;
		logic             restart;
		logic             subtract;
		logic             full;
		logic [MAG_W-1:0] mag;
	} ring_s1_t;

	// accumulate stage output
	typedef struct packed {
		logic valid;
		logic full;
	} acc_s2_t;

endpackage

// File: design/swam_ring.sv
// Ring memory of sample magnitudes with write pointer and fill tracking.
// Depends on swam_pkg.
module swam_ring (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic                              accept,
	input  logic                              clear,
	input  logic [swam_pkg::LEN_W-1:0]        win_len,
	input  logic signed [swam_pkg::SAMPLE_W-1:0] sample,
	input  logic                              restart,
	output swam_pkg::ring_s1_t                ring_s1,
	output logic [swam_pkg::MAG_W-1:0]        old_mag
);

	logic [swam_pkg::MAG_W-1:0]  mem_q [swam_pkg::WINDOW_MAX];
	logic [swam_pkg::MAG_W-1:0]  rd_q;
	logic [swam_pkg::ADDR_W-1:0] wp_q;
	logic [swam_pkg::LEN_W-1:0]  fill_q;

	logic [swam_pkg::ADDR_W-1:0] wp_eff, slot;
	logic [swam_pkg::LEN_W-1:0]  fill_eff, fill_next, slot_inc;
	logic [swam_pkg::MAG_W-1:0]  mag;
	logic                        was_full;

	always_comb begin
		mag       = sample[swam_pkg::SAMPLE_W-1] ? swam_pkg::MAG_W'(~sample + 1'b1)
		                                         : swam_pkg::MAG_W'(sample);
		wp_eff    = restart ? '0 : wp_q;
		fill_eff  = restart ? '0 : fill_q;
		slot      = ({1'b0, wp_eff} >= win_len) ? '0 : wp_eff;
		slot_inc  = {1'b0, slot} + 1'b1;
		was_full  = fill_eff >= win_len;
		fill_next = was_full ? fill_eff : fill_eff + 1'b1;
	end

	// read-first: a read of the slot being written returns the value it replaces
	always_ff @(posedge clk) begin
		if (accept) begin
			mem_q[slot] <= mag;
		end
		if (advance) begin
			rd_q <= mem_q[slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			fill_q  <= '0;
			ring_s1 <= '0;
		end else begin
			if (clear) begin
				wp_q   <= '0;
				fill_q <= '0;
			end else if (accept) begin
				wp_q   <= (slot_inc >= win_len) ? '0 : slot_inc[swam_pkg::ADDR_W-1:0];
				fill_q <= fill_next;
			end
			if (advance) begin
				ring_s1.valid <= accept;
			end
			if (accept) begin
				ring_s1.restart  <= restart;
				ring_s1.subtract <= was_full;
				ring_s1.full     <= fill_next >= win_len;
				ring_s1.mag      <= mag;
			end
		end
	end

	assign old_mag = rd_q;

endmodule

// File: design/swam_scale.sv
// Reciprocal scaling of the running sum with saturation and output register.
// Depends on swam_pkg.
module swam_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  swam_pkg::acc_s2_t             acc_s2,
	input  logic [swam_pkg::SUM_W-1:0]    sum,
	input  logic [swam_pkg::RECIP_W-1:0]  recip,
	output logic                          out_valid,
	output logic [swam_pkg::LEVEL_W-1:0]  level,
	output logic                          full
);

	logic [swam_pkg::PROD_W-1:0] prod_s3;
	logic                        valid_s3;
	logic                        full_s3;
	logic                        over;

	assign over = |prod_s3[swam_pkg::PROD_W-1:swam_pkg::FRAC_W+swam_pkg::LEVEL_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else if (advance) begin
			valid_s3  <= acc_s2.valid;
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s3 <= swam_pkg::PROD_W'(sum) * swam_pkg::PROD_W'(recip);
			full_s3 <= acc_s2.full;
			level   <= over ? '1
			                : prod_s3[swam_pkg::FRAC_W+swam_pkg::LEVEL_W-1:swam_pkg::FRAC_W];
			full    <= full_s3;
		end
	end

endmodule

// File: design/sliding_window_abs_mean.sv
// Sliding window mean of sample magnitude: ring memory, running sum, scaling.
// Depends on swam_pkg, swam_ring and swam_scale.
// Throughput: one request per cycle, sustained, with the output not stalled.
// Pipeline: an accepted request passes through registered stages in order
// (ring read, sum update, multiply, saturate into the output register).
// Reset (arst_n, async active low): history, pointer, fill and sum emptied,
// window_length = 1024, window_reciprocal = 64; ring contents are not cleared.
module sliding_window_abs_mean (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [swam_pkg::PADDR_W-1:0]   paddr,
	input  logic [swam_pkg::PDATA_W-1:0]   pwdata,
	output logic [swam_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,   // [15:0] audio_sample
	input  logic                           s_tuser,   // [0] restart
	// output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [15:0]                    m_tdata,   // [15:0] window_level
	output logic                           m_tuser    // [0] window_full
);

	logic [swam_pkg::LEN_W-1:0]   win_len_q, win_len;
	logic [swam_pkg::RECIP_W-1:0] recip_q;
	logic                         cfg_we, len_write;

	logic                         advance, accept;
	swam_pkg::ring_s1_t           ring_s1;
	logic [swam_pkg::MAG_W-1:0]   old_mag;
	swam_pkg::acc_s2_t            acc_s2;
	logic [swam_pkg::SUM_W-1:0]   sum_q, sum_base;

	// ---------------- configuration registers ----------------
	assign pready    = 1'b1;
	assign cfg_we    = psel && penable && pwrite;
	assign len_write = cfg_we && (paddr[2] == swam_pkg::REG_WINDOW_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= swam_pkg::LEN_RESET;
			recip_q   <= swam_pkg::RECIP_RESET;
		end else if (cfg_we) begin
			case (paddr[2])
				swam_pkg::REG_WINDOW_LENGTH: win_len_q <= pwdata[swam_pkg::LEN_W-1:0];
				swam_pkg::REG_WINDOW_RECIP:  recip_q   <= pwdata[swam_pkg::RECIP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			swam_pkg::REG_WINDOW_LENGTH: prdata = swam_pkg::PDATA_W'(win_len_q);
			swam_pkg::REG_WINDOW_RECIP:  prdata = swam_pkg::PDATA_W'(recip_q);
			default:                     prdata = '0;
		endcase
	end

	// effective window: zero means one, above the ring depth means full depth
	always_comb begin
		if (win_len_q == '0) begin
			win_len = swam_pkg::LEN_W'(1);
		end else if (win_len_q > swam_pkg::LEN_W'(swam_pkg::WINDOW_MAX)) begin
			win_len = swam_pkg::LEN_W'(swam_pkg::WINDOW_MAX);
		end else begin
			win_len = win_len_q;
		end
	end

	// ---------------- pipeline flow ----------------
	// whole pipe moves together; it holds only while a result waits
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance;
	assign accept   = s_tvalid && advance;

	swam_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.accept  (accept),
		.clear   (len_write),
		.win_len (win_len),
		.sample  (s_tdata),
		.restart (s_tuser),
		.ring_s1 (ring_s1),
		.old_mag (old_mag)
	);

	// ---------------- running sum ----------------
	// restart empties the sum in the same step that adds the new magnitude;
	// the oldest magnitude leaves only once the window was already full
	assign sum_base = ring_s1.restart ? '0 : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q        <= '0;
			acc_s2.valid <= 1'b0;
			acc_s2.full  <= 1'b0;
		end else begin
			if (len_write) begin
				sum_q <= '0;
			end else if (advance && ring_s1.valid) begin
				sum_q <= sum_base
				       - (ring_s1.subtract ? swam_pkg::SUM_W'(old_mag) : '0)
				       + swam_pkg::SUM_W'(ring_s1.mag);
			end
			if (advance) begin
				acc_s2.valid <= ring_s1.valid;
				acc_s2.full  <= ring_s1.full;
			end
		end
	end

	// ---------------- scaling and output ----------------
	swam_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.acc_s2    (acc_s2),
		.sum       (sum_q),
		.recip     (recip_q),
		.out_valid (m_tvalid),
		.level     (m_tdata),
		.full      (m_tuser)
	);

endmodule
